>>> hw/rtl/solq_pkg.sv
package solq_pkg;

    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 16;
    localparam int COST_BITS  = 32;
    localparam int PAY_BITS   = 32;

    typedef enum logic [1:0] {
        K_INSERT = 2'd0,
        K_POP    = 2'd1,
        K_REMOVE = 2'd2,
        K_FIND   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic run;
        logic tail;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/solq_ctrl.sv
module solq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  solq_pkg::t_sts i_sts,
    output solq_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_TAIL = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_RUN;
            S_RUN:  if (i_sts.scan_done) n_state = S_TAIL;
            S_TAIL: if (i_sts.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.run  = (r_state == S_RUN);
    assign o_cmd.tail = (r_state == S_TAIL) && i_sts.out_free;
    assign o_busy     = (r_state != S_IDLE);

endmodule

>>> hw/rtl/solq_datapath.sv
module solq_datapath #(
    parameter int CAPACITY   = solq_pkg::CAPACITY,
    parameter int COORD_BITS = solq_pkg::COORD_BITS,
    parameter int COST_BITS  = solq_pkg::COST_BITS,
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  solq_pkg::t_cmd                i_cmd,
    output solq_pkg::t_sts                o_sts,
    input  logic [1:0]                    i_kind,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    input  logic [COST_BITS-1:0]          i_cost_f,
    input  logic [solq_pkg::PAY_BITS-1:0] i_node_payload,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [COORD_BITS-1:0]         o_out_x,
    output logic [COORD_BITS-1:0]         o_out_y,
    output logic [COST_BITS-1:0]          o_out_cost,
    output logic [solq_pkg::PAY_BITS-1:0] o_out_payload,
    output logic [IW-1:0]                 o_found_index,
    output logic [CW-1:0]                 o_entry_count
);

    localparam int PW = solq_pkg::PAY_BITS;
    localparam int EW = 2 * COORD_BITS + COST_BITS + PW;

    logic [EW-1:0] r_mem [CAPACITY];

    solq_pkg::t_kind  r_kind;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [COST_BITS-1:0]  r_cost;
    logic [PW-1:0]         r_pay;
    logic [CW-1:0]  r_count, r_lim, r_rd_idx, r_pr_idx, r_w;
    logic           r_dv, r_c, r_found, r_ov;
    logic [EW-1:0]  r_rd_data, r_carry, r_head;
    logic [IW-1:0]  r_fidx;

    logic [EW-1:0]         new_ent, wd;
    logic [IW-1:0]         wa;
    logic                  we, issue, proc, full, match, ins_here;
    logic [COORD_BITS-1:0] d_x, d_y;
    logic [COST_BITS-1:0]  d_cost;
    logic [CW-1:0]         pr_m1, n_count;
    solq_pkg::t_status     n_status;

    assign new_ent  = {r_x, r_y, r_cost, r_pay};
    assign d_x      = r_rd_data[EW-1 -: COORD_BITS];
    assign d_y      = r_rd_data[EW-COORD_BITS-1 -: COORD_BITS];
    assign d_cost   = r_rd_data[PW +: COST_BITS];
    assign match    = (d_x == r_x) && (d_y == r_y);
    assign ins_here = (r_cost <= d_cost);
    assign full     = (r_count == CW'(CAPACITY));
    assign issue    = i_cmd.run && (r_rd_idx < r_lim);
    assign proc     = i_cmd.run && r_dv;
    assign pr_m1    = r_pr_idx - 1'b1;

    assign o_sts.scan_done = (r_rd_idx >= r_lim) && !r_dv;
    assign o_sts.out_free  = !r_ov || !i_stall;

    // one write per cycle; every scan write lands at or below the word in hand, the insert tail write at r_count
    always_comb begin
        we = 1'b0;
        wa = r_pr_idx[IW-1:0];
        wd = r_rd_data;
        if (proc) begin
            case (r_kind)
                solq_pkg::K_INSERT: begin
                    if (r_c) begin
                        we = 1'b1;
                        wd = r_carry;
                    end else if (ins_here) begin
                        we = 1'b1;
                        wd = new_ent;
                    end
                end
                solq_pkg::K_POP: begin
                    we = (r_pr_idx != '0);
                    wa = pr_m1[IW-1:0];
                end
                solq_pkg::K_REMOVE: begin
                    we = !match;
                    wa = r_w[IW-1:0];
                end
                default: we = 1'b0;
            endcase
        end
        if (i_cmd.tail && (r_kind == solq_pkg::K_INSERT) && !full) begin
            we = 1'b1;
            wa = r_count[IW-1:0];
            wd = r_c ? r_carry : new_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wa] <= wd;
        if (issue) r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
    end

    always_comb begin
        n_count  = r_count;
        n_status = solq_pkg::ST_OK;
        case (r_kind)
            solq_pkg::K_INSERT: begin
                if (full) n_status = solq_pkg::ST_FULL;
                else      n_count  = r_count + 1'b1;
            end
            solq_pkg::K_POP: begin
                if (r_count == '0) n_status = solq_pkg::ST_EMPTY;
                else               n_count  = r_count - 1'b1;
            end
            solq_pkg::K_REMOVE: begin
                n_count = r_w;
                if (r_w == r_count) n_status = solq_pkg::ST_NOTFOUND;
            end
            default: if (!r_found) n_status = solq_pkg::ST_NOTFOUND;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cmd.load) r_dv <= 1'b0;
            else if (i_cmd.run) r_dv <= issue;
            if (i_cmd.tail) begin
                r_count <= n_count;
                r_ov    <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= solq_pkg::t_kind'(i_kind);
            r_x      <= i_pos_x;
            r_y      <= i_pos_y;
            r_cost   <= i_cost_f;
            r_pay    <= i_node_payload;
            r_rd_idx <= '0;
            r_c      <= 1'b0;
            r_w      <= '0;
            r_found  <= 1'b0;
            r_fidx   <= '0;
            r_lim    <= ((solq_pkg::t_kind'(i_kind) == solq_pkg::K_INSERT) && full)
                        ? '0 : r_count;
        end
        if (i_cmd.run) begin
            if (issue) r_rd_idx <= r_rd_idx + 1'b1;
            r_pr_idx <= r_rd_idx;
        end
        if (proc) begin
            case (r_kind)
                solq_pkg::K_INSERT: begin
                    if (r_c || ins_here) begin
                        r_carry <= r_rd_data;
                        r_c     <= 1'b1;
                    end
                end
                solq_pkg::K_POP: if (r_pr_idx == '0) r_head <= r_rd_data;
                solq_pkg::K_REMOVE: if (!match) r_w <= r_w + 1'b1;
                default: begin
                    if (match && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_pr_idx[IW-1:0];
                    end
                end
            endcase
        end
        if (i_cmd.tail) begin
            o_status      <= n_status;
            o_entry_count <= n_count;
            o_found_index <= (r_kind == solq_pkg::K_FIND && r_found) ? r_fidx : '0;
            if (r_kind == solq_pkg::K_POP && r_count != '0) begin
                {o_out_x, o_out_y, o_out_cost, o_out_payload} <= r_head;
            end else begin
                {o_out_x, o_out_y, o_out_cost, o_out_payload} <= '0;
            end
        end
    end

    assign o_valid = r_ov;

endmodule

>>> hw/rtl/sorted_open_list_queue.sv
// Sorted open list in a two-port entry RAM, one read and one write a cycle.
// A result follows a linear pass over the held entries in the RAM; the pass is skipped
// for an empty list and for an insert when full.
// One word at a time; the next word is taken the cycle after its result is loaded,
// and a stalled result holds the next.
// Reset (synchronous, active low) empties the list; the RAM is not cleared.
module sorted_open_list_queue #(
    parameter int CAPACITY   = solq_pkg::CAPACITY,
    parameter int COORD_BITS = solq_pkg::COORD_BITS,
    parameter int COST_BITS  = solq_pkg::COST_BITS,
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_kind,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    input  logic [COST_BITS-1:0]          i_cost_f,
    input  logic [solq_pkg::PAY_BITS-1:0] i_node_payload,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [1:0]                    o_status,
    output logic [COORD_BITS-1:0]         o_out_x,
    output logic [COORD_BITS-1:0]         o_out_y,
    output logic [COST_BITS-1:0]          o_out_cost,
    output logic [solq_pkg::PAY_BITS-1:0] o_out_payload,
    output logic [IW-1:0]                 o_found_index,
    output logic [CW-1:0]                 o_entry_count
);

    solq_pkg::t_cmd cmd;
    solq_pkg::t_sts sts;

    solq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_stall)
    );

    solq_datapath #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS),
        .COST_BITS  (COST_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_cost_f       (i_cost_f),
        .i_node_payload (i_node_payload),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_cost     (o_out_cost),
        .o_out_payload  (o_out_payload),
        .o_found_index  (o_found_index),
        .o_entry_count  (o_entry_count)
    );

endmodule

>>> hw/rtl/solq_checker.sv
module solq_checker #(
    parameter int CAPACITY   = solq_pkg::CAPACITY,
    parameter int COORD_BITS = solq_pkg::COORD_BITS,
    parameter int COST_BITS  = solq_pkg::COST_BITS,
    localparam int IW = $clog2(CAPACITY),
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic [1:0]                    o_status,
    input logic [COORD_BITS-1:0]         o_out_x,
    input logic [COORD_BITS-1:0]         o_out_y,
    input logic [COST_BITS-1:0]          o_out_cost,
    input logic [solq_pkg::PAY_BITS-1:0] o_out_payload,
    input logic [IW-1:0]                 o_found_index,
    input logic [CW-1:0]                 o_entry_count
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_entry_count))
        else $error("result word dropped while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == solq_pkg::ST_EMPTY |-> o_entry_count == '0)
        else $error("empty report with entries held");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == solq_pkg::ST_FULL |-> o_entry_count == CW'(CAPACITY))
        else $error("full report below capacity");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != solq_pkg::ST_OK |-> o_out_cost == '0 && o_out_x == '0
            && o_out_y == '0 && o_out_payload == '0 && o_found_index == '0)
        else $error("data fields set on a failed word");

endmodule

bind sorted_open_list_queue solq_checker #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS),
    .COST_BITS  (COST_BITS)
) u_solq_checker (.*);
